>>> sv/ray_obb_slab_intersect_core_assert.svh
// Assertion macros for the ray / oriented box intersect core.
`ifndef RAY_OBB_SLAB_INTERSECT_CORE_ASSERT_SVH
`define RAY_OBB_SLAB_INTERSECT_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define ROBB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("robb assertion failed");
// next-cycle implication
`define ROBB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("robb assertion failed");
`else
`define ROBB_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ROBB_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/robb_pkg.sv
// ----------------------------------------------------------------------------
// robb_pkg
// Types, widths and helpers for the ray / oriented box slab intersect core.
// ----------------------------------------------------------------------------
package robb_pkg;

    localparam int COORD_BITS = 20;
    localparam int AX_BITS    = 20;
    localparam int HL_BITS    = 19;
    localparam int CFG_W      = 3 * AX_BITS;
    localparam int CFG_IDX_W  = 3;
    localparam int CTR_W      = 3 * COORD_BITS;

    // dot products
    localparam int P_W    = COORD_BITS + 1;
    localparam int PE_W   = P_W + AX_BITS;
    localparam int E_W    = PE_W + 2;
    localparam int PF_W   = 2 * AX_BITS;
    localparam int F_W    = PF_W + 2;
    localparam int HALF_SH = 18;
    localparam int H_W    = HL_BITS + HALF_SH;
    localparam int N_W    = ((E_W > H_W + 1) ? E_W : H_W + 1) + 1;

    // slab divider
    localparam int T_FRAC   = 20;
    localparam int Q_W      = 60;
    localparam int T_W      = Q_W + 1;
    localparam int NB_W     = Q_W - T_FRAC;
    localparam int NM_W     = (N_W > NB_W) ? N_W : NB_W + 1;
    localparam int DV_W     = F_W;
    localparam int R_W      = DV_W + 1;
    localparam int SC_W     = DV_W + NB_W;
    localparam int DIV_STEP = 4;
    localparam int DIV_ST   = Q_W / DIV_STEP;
    localparam logic [Q_W-1:0] T_LIM = '1;

    // hit point scaling: Q.20 * Q.18 -> Q.10
    localparam int LO_W   = 32;
    localparam int HI_W   = Q_W - LO_W;
    localparam int MD_W   = AX_BITS;
    localparam int DROP   = T_FRAC + 18 - 10;
    localparam int HI_SH  = LO_W - DROP;
    localparam int PHI_W  = HI_W + MD_W;
    localparam int PLO_W  = LO_W + MD_W;
    localparam int PM_W   = ((PHI_W + HI_SH > PLO_W - DROP) ? PHI_W + HI_SH : PLO_W - DROP) + 1;
    localparam int PS_W   = PM_W + 1;
    localparam int SUM_W  = ((PS_W > COORD_BITS) ? PS_W : COORD_BITS) + 1;

    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    localparam logic [CFG_W-1:0]   AXIS_U_RST = CFG_W'(1) << 18;
    localparam logic [CFG_W-1:0]   AXIS_V_RST = CFG_W'(1) << (AX_BITS + 18);
    localparam logic [CFG_W-1:0]   AXIS_W_RST = CFG_W'(1) << (2 * AX_BITS + 18);
    localparam logic [HL_BITS-1:0] HALF_RST   = HL_BITS'(1024);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER = 3'd0,
        CFG_AXIS_U = 3'd1,
        CFG_AXIS_V = 3'd2,
        CFG_AXIS_W = 3'd3,
        CFG_HALF_U = 3'd4,
        CFG_HALF_V = 3'd5,
        CFG_HALF_W = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] origin_x;
        logic signed [COORD_BITS-1:0] origin_y;
        logic signed [COORD_BITS-1:0] origin_z;
        logic signed [AX_BITS-1:0]    dir_x;
        logic signed [AX_BITS-1:0]    dir_y;
        logic signed [AX_BITS-1:0]    dir_z;
    } t_ray_in;

    typedef struct packed {
        logic                         hit;
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic signed [COORD_BITS-1:0] point_z;
    } t_ray_out;

    // one slab quotient in flight
    typedef struct packed {
        logic [R_W-1:0]  r;
        logic [NB_W-1:0] nb;
        logic [Q_W-1:0]  q;
        logic            sat;
        logic            neg;
    } t_div;

    // per-axis side info
    typedef struct packed {
        logic [DV_W-1:0] dv;
        logic            par;
        logic            outs;
    } t_axis;

    // DIV_STEP restoring division steps
    function automatic t_div div_steps(t_div d, logic [DV_W-1:0] dv);
        t_div           x;
        logic [R_W-1:0] rr;
        x = d;
        for (int k = 0; k < DIV_STEP; k++) begin
            rr   = {x.r[R_W-2:0], x.nb[NB_W-1]};
            x.nb = {x.nb[NB_W-2:0], 1'b0};
            if (rr >= {1'b0, dv}) begin
                x.r = rr - {1'b0, dv};
                x.q = {x.q[Q_W-2:0], 1'b1};
            end else begin
                x.r = rr;
                x.q = {x.q[Q_W-2:0], 1'b0};
            end
        end
        return x;
    endfunction

endpackage

>>> sv/ray_obb_slab_intersect_core.sv
// ----------------------------------------------------------------------------
// ray_obb_slab_intersect_core
// Ray against oriented box, slab method, fully pipelined fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input request: i_in_valid / o_in_stall with i_in_data (origin Q10.10,
//   direction Q1.18). Result request: o_out_valid / i_out_stall with
//   o_out_data (hit flag and saturated hit point, zero on a miss).
//   A request moves on an edge where valid is high and stall is low.
//   Box registers are written over i_cfg_valid / o_cfg_ready (always
//   ready) with i_cfg_index and i_cfg_data. The user must write them only
//   while the pipe is empty; the block itself does not enforce this.
//   Throughput: one ray per cycle when not stalled. The pipe is 25 register
//   stages: dot products, a 15-stage restoring divider (4 quotient bits per
//   stage, six slab quotients in parallel), min/max, scaling and the output
//   reg. If the receiver stalls, one more result lands in a skid register and
//   then the whole pipe holds; o_in_stall is high while the skid is full.
//   Reset clears all valid bits and loads the default unit box at origin.
// ----------------------------------------------------------------------------
`include "ray_obb_slab_intersect_core_assert.svh"

module ray_obb_slab_intersect_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  robb_pkg::t_ray_in               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output robb_pkg::t_ray_out              o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [robb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [robb_pkg::CFG_W-1:0]      i_cfg_data
);

    localparam int CB      = robb_pkg::COORD_BITS;
    localparam int AXB     = robb_pkg::AX_BITS;
    localparam int DIV_ST  = robb_pkg::DIV_ST;
    localparam int ST_P    = 0;
    localparam int ST_MUL  = 1;
    localparam int ST_SUM  = 2;
    localparam int ST_NUM  = 3;
    localparam int ST_DIV0 = 4;
    localparam int ST_T    = ST_DIV0 + DIV_ST + 1;
    localparam int ST_CMB  = ST_T + 1;
    localparam int ST_SEL  = ST_CMB + 1;
    localparam int ST_SCL  = ST_SEL + 1;
    localparam int NST     = ST_SCL + 1;

    function automatic logic signed [CB-1:0] f_org(robb_pkg::t_ray_in r, int j);
        case (j)
            0:       return r.origin_x;
            1:       return r.origin_y;
            default: return r.origin_z;
        endcase
    endfunction

    function automatic logic signed [AXB-1:0] f_dir(robb_pkg::t_ray_in r, int j);
        case (j)
            0:       return r.dir_x;
            1:       return r.dir_y;
            default: return r.dir_z;
        endcase
    endfunction

    // ---------------- configuration ----------------
    logic [robb_pkg::CTR_W-1:0]           r_center;
    logic [2:0][robb_pkg::CFG_W-1:0]      r_axis;
    logic [2:0][robb_pkg::HL_BITS-1:0]    r_half;
    logic [robb_pkg::CTR_W+robb_pkg::CFG_W-1:0] w_ctr_ext;

    assign o_cfg_ready = 1'b1;
    assign w_ctr_ext   = {{robb_pkg::CTR_W{1'b0}}, i_cfg_data};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= '0;
            r_axis[0] <= robb_pkg::AXIS_U_RST;
            r_axis[1] <= robb_pkg::AXIS_V_RST;
            r_axis[2] <= robb_pkg::AXIS_W_RST;
            r_half[0] <= robb_pkg::HALF_RST;
            r_half[1] <= robb_pkg::HALF_RST;
            r_half[2] <= robb_pkg::HALF_RST;
        end else if (i_cfg_valid) begin
            unique case (robb_pkg::t_cfg_reg'(i_cfg_index))
                robb_pkg::CFG_CENTER: r_center <= w_ctr_ext[robb_pkg::CTR_W-1:0];
                robb_pkg::CFG_AXIS_U: r_axis[0] <= i_cfg_data;
                robb_pkg::CFG_AXIS_V: r_axis[1] <= i_cfg_data;
                robb_pkg::CFG_AXIS_W: r_axis[2] <= i_cfg_data;
                robb_pkg::CFG_HALF_U: r_half[0] <= i_cfg_data[robb_pkg::HL_BITS-1:0];
                robb_pkg::CFG_HALF_V: r_half[1] <= i_cfg_data[robb_pkg::HL_BITS-1:0];
                robb_pkg::CFG_HALF_W: r_half[2] <= i_cfg_data[robb_pkg::HL_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipe control ----------------
    logic [NST-1:0] r_vld;
    logic           w_adv;
    logic           r_skid_vld;

    assign w_adv      = !r_skid_vld;
    assign o_in_stall = r_skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NST-2:0], i_in_valid};
        end
    end

    robb_pkg::t_ray_in r_ray [NST];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ray[0] <= i_in_data;
            for (int k = 1; k < NST; k++) r_ray[k] <= r_ray[k-1];
        end
    end

    // ---------------- stage P: center - origin ----------------
    logic signed [robb_pkg::P_W-1:0] r_p [3];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int j = 0; j < 3; j++) begin
                r_p[j] <= robb_pkg::P_W'(signed'(r_center[j*CB +: CB]))
                        - robb_pkg::P_W'(f_org(i_in_data, j));
            end
        end
    end

    // ---------------- stage MUL: axis products ----------------
    logic signed [robb_pkg::PE_W-1:0] r_pe [3][3];
    logic signed [robb_pkg::PF_W-1:0] r_pf [3][3];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_pe[i][j] <= robb_pkg::PE_W'(signed'(r_axis[i][j*AXB +: AXB]))
                                * robb_pkg::PE_W'(r_p[j]);
                    r_pf[i][j] <= robb_pkg::PF_W'(signed'(r_axis[i][j*AXB +: AXB]))
                                * robb_pkg::PF_W'(f_dir(r_ray[ST_P], j));
                end
            end
        end
    end

    // ---------------- stage SUM: e and f ----------------
    logic signed [robb_pkg::E_W-1:0] r_e [3];
    logic signed [robb_pkg::F_W-1:0] r_f [3];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_e[i] <= robb_pkg::E_W'(r_pe[i][0]) + robb_pkg::E_W'(r_pe[i][1])
                        + robb_pkg::E_W'(r_pe[i][2]);
                r_f[i] <= robb_pkg::F_W'(r_pf[i][0]) + robb_pkg::F_W'(r_pf[i][1])
                        + robb_pkg::F_W'(r_pf[i][2]);
            end
        end
    end

    // ---------------- stage NUM: e +- h, magnitudes ----------------
    logic signed [robb_pkg::N_W-1:0] w_es  [3];
    logic signed [robb_pkg::N_W-1:0] w_hs  [3];
    logic signed [robb_pkg::N_W-1:0] w_num [3][2];
    logic [robb_pkg::NM_W-1:0]       r_num [3][2];
    logic                            r_nneg [3][2];
    robb_pkg::t_axis                 r_nax [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_es[i]     = robb_pkg::N_W'(r_e[i]);
            w_hs[i]     = robb_pkg::N_W'(signed'({1'b0, r_half[i],
                                                 {robb_pkg::HALF_SH{1'b0}}}));
            w_num[i][0] = w_es[i] + w_hs[i];
            w_num[i][1] = w_es[i] - w_hs[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                for (int s = 0; s < 2; s++) begin
                    r_num[i][s]  <= robb_pkg::NM_W'((w_num[i][s] < 0) ? -w_num[i][s]
                                                                      : w_num[i][s]);
                    r_nneg[i][s] <= (w_num[i][s] < 0) != (r_f[i] < 0);
                end
                r_nax[i].dv   <= (r_f[i] < 0) ? robb_pkg::DV_W'(-r_f[i])
                                              : robb_pkg::DV_W'(r_f[i]);
                r_nax[i].par  <= (r_f[i] == '0);
                // parallel slab: origin outside when e beyond +-h
                r_nax[i].outs <= (w_es[i] > w_hs[i]) || (w_es[i] < -w_hs[i]);
            end
        end
    end

    // ---------------- divider: init and steps ----------------
    robb_pkg::t_div  r_div [DIV_ST+1][3][2];
    robb_pkg::t_axis r_axs [DIV_ST+1][3];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_axs[0][i] <= r_nax[i];
                for (int s = 0; s < 2; s++) begin
                    // quotient >= 2^60 exactly when n >= dv * 2^40
                    r_div[0][i][s].sat <= robb_pkg::SC_W'(r_num[i][s])
                                        >= {r_nax[i].dv, {robb_pkg::NB_W{1'b0}}};
                    r_div[0][i][s].r   <= robb_pkg::R_W'(r_num[i][s] >> robb_pkg::NB_W);
                    r_div[0][i][s].nb  <= r_num[i][s][robb_pkg::NB_W-1:0];
                    r_div[0][i][s].q   <= '0;
                    r_div[0][i][s].neg <= r_nneg[i][s];
                end
            end
            for (int d = 1; d <= DIV_ST; d++) begin
                for (int i = 0; i < 3; i++) begin
                    r_axs[d][i] <= r_axs[d-1][i];
                    for (int s = 0; s < 2; s++) begin
                        r_div[d][i][s] <= robb_pkg::div_steps(r_div[d-1][i][s],
                                                              r_axs[d-1][i].dv);
                    end
                end
            end
        end
    end

    // ---------------- stage T: signed distances, ordered ----------------
    logic [robb_pkg::Q_W-1:0]        w_m [3][2];
    logic signed [robb_pkg::T_W-1:0] w_t [3][2];
    logic signed [robb_pkg::T_W-1:0] r_tlo [3];
    logic signed [robb_pkg::T_W-1:0] r_thi [3];
    robb_pkg::t_axis                 r_tax [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int s = 0; s < 2; s++) begin
                w_m[i][s] = r_div[DIV_ST][i][s].sat ? robb_pkg::T_LIM : r_div[DIV_ST][i][s].q;
                w_t[i][s] = r_div[DIV_ST][i][s].neg ? -signed'({1'b0, w_m[i][s]})
                                                    : signed'({1'b0, w_m[i][s]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_tax[i] <= r_axs[DIV_ST][i];
                if (w_t[i][0] > w_t[i][1]) begin
                    r_tlo[i] <= w_t[i][1];
                    r_thi[i] <= w_t[i][0];
                end else begin
                    r_tlo[i] <= w_t[i][0];
                    r_thi[i] <= w_t[i][1];
                end
            end
        end
    end

    // ---------------- stage CMB: entry / exit ----------------
    logic signed [robb_pkg::T_W-1:0] w_tmin, w_tmax;
    logic                            w_have, w_pmiss;
    logic signed [robb_pkg::T_W-1:0] r_tmin, r_tmax;
    logic                            r_have, r_pmiss;

    always_comb begin
        w_tmin  = '0;
        w_tmax  = '0;
        w_have  = 1'b0;
        w_pmiss = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (r_tax[i].par) begin
                w_pmiss = w_pmiss | r_tax[i].outs;
            end else begin
                if (!w_have || r_tlo[i] > w_tmin) w_tmin = r_tlo[i];
                if (!w_have || r_thi[i] < w_tmax) w_tmax = r_thi[i];
                w_have = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_tmin  <= w_tmin;
            r_tmax  <= w_tmax;
            r_have  <= w_have;
            r_pmiss <= w_pmiss;
        end
    end

    // ---------------- stage SEL: hit decision, chosen t ----------------
    logic signed [robb_pkg::T_W-1:0] w_tsel;
    logic                            r_shit, r_shave, r_tneg;
    logic [robb_pkg::Q_W-1:0]        r_mt;

    assign w_tsel = (r_tmin > 0) ? r_tmin : r_tmax;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_shit  <= !(r_pmiss || (r_have && ((r_tmin > r_tmax) || (r_tmax < 0))));
            r_shave <= r_have;
            r_tneg  <= (w_tsel < 0);
            r_mt    <= (w_tsel < 0) ? robb_pkg::Q_W'(-w_tsel) : robb_pkg::Q_W'(w_tsel);
        end
    end

    // ---------------- stage SCL: t * dir partial products ----------------
    logic [robb_pkg::MD_W-1:0]  w_md [3];
    logic [robb_pkg::PHI_W-1:0] r_phi [3];
    logic [robb_pkg::PLO_W-1:0] r_plo [3];
    logic                       r_sneg [3];
    logic                       r_chit, r_chave;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_md[j] = (f_dir(r_ray[ST_SEL], j) < 0) ? robb_pkg::MD_W'(-f_dir(r_ray[ST_SEL], j))
                                                    : robb_pkg::MD_W'(f_dir(r_ray[ST_SEL], j));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_chit  <= r_shit;
            r_chave <= r_shave;
            for (int j = 0; j < 3; j++) begin
                r_phi[j]  <= robb_pkg::PHI_W'(r_mt[robb_pkg::Q_W-1:robb_pkg::LO_W])
                           * robb_pkg::PHI_W'(w_md[j]);
                r_plo[j]  <= robb_pkg::PLO_W'(r_mt[robb_pkg::LO_W-1:0])
                           * robb_pkg::PLO_W'(w_md[j]);
                r_sneg[j] <= r_tneg != (f_dir(r_ray[ST_SEL], j) < 0);
            end
        end
    end

    // ---------------- final: offset + origin, saturate ----------------
    logic [robb_pkg::PM_W-1:0]          w_pm  [3];
    logic signed [robb_pkg::PS_W-1:0]   w_ps  [3];
    logic signed [robb_pkg::SUM_W-1:0]  w_sum [3];
    logic signed [CB-1:0]               w_pt  [3];
    robb_pkg::t_ray_out                 w_res;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_pm[j]  = robb_pkg::PM_W'({r_phi[j], {robb_pkg::HI_SH{1'b0}}})
                     + robb_pkg::PM_W'(r_plo[j] >> robb_pkg::DROP);
            w_ps[j]  = r_sneg[j] ? -signed'({1'b0, w_pm[j]}) : signed'({1'b0, w_pm[j]});
            w_sum[j] = robb_pkg::SUM_W'(f_org(r_ray[ST_SCL], j)) + robb_pkg::SUM_W'(w_ps[j]);
            if (!r_chit) begin
                w_pt[j] = '0;
            end else if (!r_chave) begin
                w_pt[j] = f_org(r_ray[ST_SCL], j);
            end else if (w_sum[j] > robb_pkg::SUM_W'(robb_pkg::COORD_MAX)) begin
                w_pt[j] = robb_pkg::COORD_MAX;
            end else if (w_sum[j] < robb_pkg::SUM_W'(robb_pkg::COORD_MIN)) begin
                w_pt[j] = robb_pkg::COORD_MIN;
            end else begin
                w_pt[j] = w_sum[j][CB-1:0];
            end
        end
        w_res.hit     = r_chit;
        w_res.point_x = w_pt[0];
        w_res.point_y = w_pt[1];
        w_res.point_z = w_pt[2];
    end

    // ---------------- output register + skid ----------------
    logic               r_out_vld;
    robb_pkg::t_ray_out r_out, r_skid;
    logic               w_push, w_pop;

    assign w_push = r_vld[ST_SCL] && w_adv;
    assign w_pop  = r_out_vld && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || w_pop) begin
            if (r_skid_vld) begin
                r_out      <= r_skid;
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out      <= w_res;
                r_out_vld  <= w_push;
            end
        end else if (w_push) begin
            r_skid     <= w_res;
            r_skid_vld <= 1'b1;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // ---------------- assertions ----------------
    `ROBB_ASSERT_IMP(a_miss_zero, i_clk, i_rst_n, o_out_valid && !o_out_data.hit,
        o_out_data.point_x == '0 && o_out_data.point_y == '0 && o_out_data.point_z == '0)
    `ROBB_ASSERT_IMP(a_div_rem, i_clk, i_rst_n,
        r_vld[ST_T-1] && !r_axs[DIV_ST][0].par && !r_div[DIV_ST][0][0].sat,
        r_div[DIV_ST][0][0].r < {1'b0, r_axs[DIV_ST][0].dv})
    `ROBB_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_vld, r_out_vld)
    `ROBB_ASSERT_NXT(a_skid_drains, i_clk, i_rst_n, r_skid_vld && !i_out_stall, !r_skid_vld)

endmodule
